// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions for the complex ALU, masked during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define CNA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define CNA_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// ===== hw/rtl/cna_pkg.sv =====
// ----------------------------------------------------------------------------
// cna_pkg
// Types, opcodes, latencies and helper functions of the complex ALU.
// ----------------------------------------------------------------------------
package cna_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int GUARD_BITS   = 8;
   localparam int DW           = 32;
   localparam int CW           = 44;   // CORDIC x/y width
   localparam int ZW           = 35;   // CORDIC angle width, Q30
   localparam int GW           = 31;   // gain width
   localparam int SAT_W        = 66;
   localparam int DIV_BITS     = 32;

   localparam longint KINF_Q30 = 64'sd652032874;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint GAIN_Q30 = KINF_Q30 + ((2 * KINF_Q30 / 3) >>> (2 * CORDIC_N));
   localparam logic signed [31:0] PI_OUT =
      32'((PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_CONJ  = 3'd4;
   localparam logic [2:0] OP_SCALE = 3'd5;
   localparam logic [2:0] OP_MAG   = 3'd6;
   localparam logic [2:0] OP_ANGLE = 3'd7;

   // Stage counts, input port is stage 0
   localparam int MUL_LAT    = 3;
   localparam int DIV_LAT    = MUL_LAT + DIV_BITS + 1;
   localparam int CORDIC_LAT = CORDIC_N + 3;
   localparam int PIPE_LAT   = DIV_LAT;
   localparam int EARLY_DLY  = PIPE_LAT - MUL_LAT;
   localparam int CORD_DLY   = PIPE_LAT - CORDIC_LAT;

   localparam logic signed [SAT_W-1:0] S_MAX = 66'sd2147483647;
   localparam logic signed [SAT_W-1:0] S_MIN = -66'sd2147483648;
   localparam logic signed [31:0] R_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] R_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               ovf;
      logic               dz;
   } res_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   function automatic logic signed [SAT_W-1:0] sx66(input logic signed [31:0] x);
      return {{(SAT_W - 32){x[31]}}, x};
   endfunction

   function automatic sat_type sat32(input logic signed [SAT_W-1:0] v);
      sat_type s;
      if (v > S_MAX) begin
         s.val = R_MAX;
         s.ovf = 1'b1;
      end else if (v < S_MIN) begin
         s.val = R_MIN;
         s.ovf = 1'b1;
      end else begin
         s.val = v[31:0];
         s.ovf = 1'b0;
      end
      return s;
   endfunction

   // atan(2^-i) in Q30, truncated
   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] a;
      case (idx)
         0:  a = 30'd843314856;
         1:  a = 30'd497837829;
         2:  a = 30'd263043836;
         3:  a = 30'd133525158;
         4:  a = 30'd67021686;
         5:  a = 30'd33543515;
         6:  a = 30'd16775850;
         7:  a = 30'd8388437;
         8:  a = 30'd4194282;
         9:  a = 30'd2097149;
         10: a = 30'd1048575;
         11: a = 30'd524287;
         12: a = 30'd262143;
         13: a = 30'd131071;
         14: a = 30'd65535;
         15: a = 30'd32767;
         16: a = 30'd16383;
         17: a = 30'd8191;
         18: a = 30'd4095;
         19: a = 30'd2047;
         20: a = 30'd1023;
         21: a = 30'd511;
         22: a = 30'd255;
         23: a = 30'd127;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/cna_mult.sv =====
// ----------------------------------------------------------------------------
// cna_mult
// Product stage: operand products, sums for mul/scale/div, floor and saturate.
// ----------------------------------------------------------------------------
module cna_mult (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [2:0]           op,
   input  logic signed [31:0]   a_re,
   input  logic signed [31:0]   a_im,
   input  logic signed [31:0]   b_re,
   input  logic signed [31:0]   b_im,
   output logic signed [64:0]   wide_re,
   output logic signed [64:0]   wide_im,
   output logic [63:0]          den,
   output cna_pkg::res_type     prod
);

   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic [2:0]         op_ff;
   logic signed [64:0] w_re_in, w_im_in, w_re_ff, w_im_ff;
   logic [63:0]        den_in, den_ff;
   logic signed [64:0] sh_re, sh_im;
   cna_pkg::sat_type   s_re, s_im;
   cna_pkg::res_type   prod_in, prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_rr_ff <= a_re * b_re;
         p_ii_ff <= a_im * b_im;
         p_ri_ff <= a_re * b_im;
         p_ir_ff <= a_im * b_re;
         p_bb_ff <= b_re * b_re;
         p_cc_ff <= b_im * b_im;
         op_ff   <= op;
      end
   end

   always_comb begin
      case (op_ff)
         cna_pkg::OP_MUL: begin
            w_re_in = 65'(p_rr_ff) - 65'(p_ii_ff);
            w_im_in = 65'(p_ri_ff) + 65'(p_ir_ff);
         end
         cna_pkg::OP_DIV: begin
            // numerator of a * conj(b)
            w_re_in = 65'(p_rr_ff) + 65'(p_ii_ff);
            w_im_in = 65'(p_ir_ff) - 65'(p_ri_ff);
         end
         default: begin
            w_re_in = 65'(p_rr_ff);
            w_im_in = 65'(p_ir_ff);
         end
      endcase
      den_in = p_bb_ff + p_cc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_re_ff <= w_re_in;
         w_im_ff <= w_im_in;
         den_ff  <= den_in;
      end
   end

   // arithmetic shift is floor division
   always_comb begin
      sh_re       = w_re_ff >>> cna_pkg::FRAC_BITS;
      sh_im       = w_im_ff >>> cna_pkg::FRAC_BITS;
      s_re        = cna_pkg::sat32({sh_re[64], sh_re});
      s_im        = cna_pkg::sat32({sh_im[64], sh_im});
      prod_in.re  = s_re.val;
      prod_in.im  = s_im.val;
      prod_in.ovf = s_re.ovf | s_im.ovf;
      prod_in.dz  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   assign wide_re = w_re_ff;
   assign wide_im = w_im_ff;
   assign den     = den_ff;
   assign prod    = prod_ff;

endmodule

// ===== hw/rtl/cna_div.sv =====
// ----------------------------------------------------------------------------
// cna_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// ----------------------------------------------------------------------------
module cna_div (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [64:0]   wide_re,
   input  logic signed [64:0]   wide_im,
   input  logic [63:0]          den,
   output cna_pkg::res_type     div_res
);

   localparam int NB = cna_pkg::DIV_BITS;
   localparam int HI = NB - cna_pkg::FRAC_BITS;

   logic [63:0] rem_re_ff [0:NB];
   logic [63:0] rem_im_ff [0:NB];
   logic [31:0] nq_re_ff  [0:NB];
   logic [31:0] nq_im_ff  [0:NB];
   logic [63:0] den_ff    [0:NB];
   logic [NB:0] neg_re_ff, neg_im_ff, big_re_ff, big_im_ff, dz_ff;

   logic [64:0] m_re, m_im;
   logic [63:0] top_re, top_im;
   cna_pkg::sat_type s_re, s_im;
   cna_pkg::res_type res_in, res_ff;

   function automatic cna_pkg::sat_type sat_mag(input logic neg, input logic big,
                                                input logic [31:0] q);
      cna_pkg::sat_type s;
      s.ovf = 1'b0;
      if (big) begin
         s.val = neg ? cna_pkg::R_MIN : cna_pkg::R_MAX;
         s.ovf = 1'b1;
      end else if (neg) begin
         if (q > 32'h8000_0000) begin
            s.val = cna_pkg::R_MIN;
            s.ovf = 1'b1;
         end else begin
            s.val = -q;
         end
      end else if (q[31]) begin
         s.val = cna_pkg::R_MAX;
         s.ovf = 1'b1;
      end else begin
         s.val = q;
      end
      return s;
   endfunction

   // setup: sign/magnitude, high dividend word as first remainder
   always_comb begin
      m_re   = wide_re[64] ? -wide_re : wide_re;
      m_im   = wide_im[64] ? -wide_im : wide_im;
      top_re = m_re[63:0] >> HI;
      top_im = m_im[63:0] >> HI;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_re_ff[0] <= top_re;
         rem_im_ff[0] <= top_im;
         nq_re_ff[0]  <= m_re[31:0] << cna_pkg::FRAC_BITS;
         nq_im_ff[0]  <= m_im[31:0] << cna_pkg::FRAC_BITS;
         den_ff[0]    <= den;
         neg_re_ff[0] <= wide_re[64];
         neg_im_ff[0] <= wide_im[64];
         big_re_ff[0] <= top_re >= den;
         big_im_ff[0] <= top_im >= den;
         dz_ff[0]     <= den == 64'd0;
      end
   end

   for (genvar k = 1; k <= NB; k++) begin : g_bit
      logic [64:0] r2_re, r2_im;
      logic        ge_re, ge_im;
      assign r2_re = {rem_re_ff[k-1], nq_re_ff[k-1][31]};
      assign r2_im = {rem_im_ff[k-1], nq_im_ff[k-1][31]};
      assign ge_re = r2_re >= {1'b0, den_ff[k-1]};
      assign ge_im = r2_im >= {1'b0, den_ff[k-1]};

      // dividend bits shift out of nq as quotient bits shift in
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_re_ff[k] <= ge_re ? 64'(r2_re - {1'b0, den_ff[k-1]}) : r2_re[63:0];
            rem_im_ff[k] <= ge_im ? 64'(r2_im - {1'b0, den_ff[k-1]}) : r2_im[63:0];
            nq_re_ff[k]  <= {nq_re_ff[k-1][30:0], ge_re};
            nq_im_ff[k]  <= {nq_im_ff[k-1][30:0], ge_im};
            den_ff[k]    <= den_ff[k-1];
            neg_re_ff[k] <= neg_re_ff[k-1];
            neg_im_ff[k] <= neg_im_ff[k-1];
            big_re_ff[k] <= big_re_ff[k-1];
            big_im_ff[k] <= big_im_ff[k-1];
            dz_ff[k]     <= dz_ff[k-1];
         end
      end
   end

   always_comb begin
      s_re = sat_mag(neg_re_ff[NB], big_re_ff[NB], nq_re_ff[NB]);
      s_im = sat_mag(neg_im_ff[NB], big_im_ff[NB], nq_im_ff[NB]);
      if (dz_ff[NB]) begin
         res_in.re  = '0;
         res_in.im  = '0;
         res_in.ovf = 1'b0;
         res_in.dz  = 1'b1;
      end else begin
         res_in.re  = s_re.val;
         res_in.im  = s_im.val;
         res_in.ovf = s_re.ovf | s_im.ovf;
         res_in.dz  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign div_res = res_ff;

endmodule

// ===== hw/rtl/cna_cordic.sv =====
// ----------------------------------------------------------------------------
// cna_cordic
// Vectoring CORDIC pipeline, one micro-rotation per stage; magnitude or angle.
// ----------------------------------------------------------------------------
module cna_cordic (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [2:0]           op,
   input  logic signed [31:0]   a_re,
   input  logic signed [31:0]   a_im,
   output cna_pkg::res_type     cord_res
);

   localparam int N  = cna_pkg::CORDIC_N;
   localparam int CW = cna_pkg::CW;
   localparam int ZW = cna_pkg::ZW;
   localparam int GW = cna_pkg::GW;
   localparam int HW = CW - 17;
   localparam int TW = HW + GW + 1;
   localparam logic [GW-1:0] GAIN = GW'(cna_pkg::GAIN_Q30);
   localparam logic signed [ZW-1:0] PI_Z = ZW'(cna_pkg::PI_Q30);
   localparam logic signed [ZW-1:0] HALF_Z = ZW'(64'sd1 <<< (29 - cna_pkg::FRAC_BITS));

   logic signed [CW-1:0] x_ff [0:N];
   logic signed [CW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic [N:0]           ang_ff, orig_ff;

   logic signed [CW-1:0] x_pre, y_pre, x0_in, y0_in;
   logic signed [ZW-1:0] z0_in, zc, zr;
   logic [HW+GW-1:0]     ph_in, ph_ff;
   logic [16+GW-1:0]     pl_in, pl_ff;
   logic signed [31:0]   av_in, av_ff;
   logic                 ang1_ff, orig1_ff;
   logic [TW-1:0]        t_sum;
   logic [TW-23:0]       mag;
   cna_pkg::res_type     res_in, res_ff;

   always_comb begin
      x_pre = {{(CW - 32 - cna_pkg::GUARD_BITS){a_re[31]}}, a_re,
               {cna_pkg::GUARD_BITS{1'b0}}};
      y_pre = {{(CW - 32 - cna_pkg::GUARD_BITS){a_im[31]}}, a_im,
               {cna_pkg::GUARD_BITS{1'b0}}};
      // left half plane: rotate by pi first
      if (a_re[31]) begin
         x0_in = -x_pre;
         y0_in = -y_pre;
         z0_in = a_im[31] ? -PI_Z : PI_Z;
      end else begin
         x0_in = x_pre;
         y0_in = y_pre;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         ang_ff[0]  <= op == cna_pkg::OP_ANGLE;
         orig_ff[0] <= (a_re == 32'sd0) && (a_im == 32'sd0);
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      localparam logic signed [ZW-1:0] ANG = ZW'(cna_pkg::atan_q30(k - 1));
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[k-1] >>> (k - 1);
      assign dy = x_ff[k-1] >>> (k - 1);

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!y_ff[k-1][CW-1]) begin
               x_ff[k] <= x_ff[k-1] + dx;
               y_ff[k] <= y_ff[k-1] - dy;
               z_ff[k] <= z_ff[k-1] + ANG;
            end else begin
               x_ff[k] <= x_ff[k-1] - dx;
               y_ff[k] <= y_ff[k-1] + dy;
               z_ff[k] <= z_ff[k-1] - ANG;
            end
            ang_ff[k]  <= ang_ff[k-1];
            orig_ff[k] <= orig_ff[k-1];
         end
      end
   end

   // gain split into high and low products; x is never negative here
   always_comb begin
      ph_in = x_ff[N][CW-2:16] * GAIN;
      pl_in = x_ff[N][15:0] * GAIN;
      if (z_ff[N] > PI_Z) begin
         zc = PI_Z;
      end else if (z_ff[N] < -PI_Z) begin
         zc = -PI_Z;
      end else begin
         zc = z_ff[N];
      end
      zr    = zc + HALF_Z;
      av_in = 32'(zr >>> (30 - cna_pkg::FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         av_ff    <= av_in;
         ang1_ff  <= ang_ff[N];
         orig1_ff <= orig_ff[N];
      end
   end

   always_comb begin
      t_sum  = {1'b0, ph_ff} + TW'(pl_ff >> 16);
      mag    = (TW-22)'(t_sum >> (14 + cna_pkg::GUARD_BITS));
      res_in.im = '0;
      res_in.dz = 1'b0;
      if (ang1_ff) begin
         res_in.re  = orig1_ff ? 32'sd0 : av_ff;
         res_in.ovf = 1'b0;
      end else if (mag > (TW-22)'(32'h7FFF_FFFF)) begin
         res_in.re  = cna_pkg::R_MAX;
         res_in.ovf = 1'b1;
      end else begin
         res_in.re  = mag[31:0];
         res_in.ovf = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign cord_res = res_ff;

endmodule

// ===== hw/rtl/complex_number_alu.sv =====
// ----------------------------------------------------------------------------
// complex_number_alu
// Pipelined Q16.16 complex ALU: add, sub, mul, div, conjugate, scale,
// magnitude and angle (CORDIC), with saturation and divide-by-zero flags.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  req_opcode, req_a_re, req_a_im,
//                                    req_b_re, req_b_im
//   response  rsp_valid / rsp_stall  rsp_res_re, rsp_res_im, rsp_overflow,
//                                    rsp_div_by_zero
//
// One request per cycle while req_stall is low. The pipeline depth is set by the
// 32-stage restoring divider; other opcodes are delayed to match.
// Reset clears only the valid bits.
// rsp_stall on a held response freezes every stage; req_stall follows it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_number_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_opcode,
   input  logic signed [31:0]   req_a_re,
   input  logic signed [31:0]   req_a_im,
   input  logic signed [31:0]   req_b_re,
   input  logic signed [31:0]   req_b_im,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_res_re,
   output logic signed [31:0]   rsp_res_im,
   output logic                 rsp_overflow,
   output logic                 rsp_div_by_zero
);

   localparam int PL = cna_pkg::PIPE_LAT;
   localparam int ML = cna_pkg::MUL_LAT;
   localparam int ED = cna_pkg::EARLY_DLY;
   localparam int CD = cna_pkg::CORD_DLY;

   logic                adv;
   logic [PL-1:0]       vld_ff;
   logic [2:0]          op_ff [0:PL-1];
   cna_pkg::res_type    simp_in;
   cna_pkg::res_type    simp_ff  [0:ML-1];
   cna_pkg::res_type    early_in;
   cna_pkg::res_type    early_ff [0:ED-1];
   cna_pkg::res_type    cord_ff  [0:CD-1];
   cna_pkg::res_type    out_in, out_ff;
   cna_pkg::res_type    prod, div_res, cord_res;
   cna_pkg::sat_type    s_re, s_im;
   logic                rsp_valid_ff;
   logic [2:0]          out_op_ff;
   logic signed [64:0]  wide_re, wide_im;
   logic [63:0]         den;

   // whole pipeline moves unless a finished response is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   cna_mult u_mult (
      .clock   (clock),
      .adv     (adv),
      .op      (req_opcode),
      .a_re    (req_a_re),
      .a_im    (req_a_im),
      .b_re    (req_b_re),
      .b_im    (req_b_im),
      .wide_re (wide_re),
      .wide_im (wide_im),
      .den     (den),
      .prod    (prod)
   );

   cna_div u_div (
      .clock   (clock),
      .adv     (adv),
      .wide_re (wide_re),
      .wide_im (wide_im),
      .den     (den),
      .div_res (div_res)
   );

   cna_cordic u_cordic (
      .clock    (clock),
      .adv      (adv),
      .op       (req_opcode),
      .a_re     (req_a_re),
      .a_im     (req_a_im),
      .cord_res (cord_res)
   );

   always_comb begin
      s_re = '0;
      s_im = '0;
      case (req_opcode)
         cna_pkg::OP_ADD: begin
            s_re = cna_pkg::sat32(cna_pkg::sx66(req_a_re) + cna_pkg::sx66(req_b_re));
            s_im = cna_pkg::sat32(cna_pkg::sx66(req_a_im) + cna_pkg::sx66(req_b_im));
         end
         cna_pkg::OP_SUB: begin
            s_re = cna_pkg::sat32(cna_pkg::sx66(req_a_re) - cna_pkg::sx66(req_b_re));
            s_im = cna_pkg::sat32(cna_pkg::sx66(req_a_im) - cna_pkg::sx66(req_b_im));
         end
         cna_pkg::OP_CONJ: begin
            s_re = cna_pkg::sat32(cna_pkg::sx66(req_a_re));
            s_im = cna_pkg::sat32(-cna_pkg::sx66(req_a_im));
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      simp_in.re  = s_re.val;
      simp_in.im  = s_im.val;
      simp_in.ovf = s_re.ovf | s_im.ovf;
      simp_in.dz  = 1'b0;
   end

   always_comb begin
      case (op_ff[ML-1]) inside
         cna_pkg::OP_MUL, cna_pkg::OP_SCALE: early_in = prod;
         default:                            early_in = simp_ff[ML-1];
      endcase
   end

   always_comb begin
      case (op_ff[PL-1]) inside
         cna_pkg::OP_DIV:                    out_in = div_res;
         cna_pkg::OP_MAG, cna_pkg::OP_ANGLE: out_in = cord_ff[CD-1];
         default:                            out_in = early_ff[ED-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PL-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0]    <= req_opcode;
         for (int k = 1; k < PL; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
         simp_ff[0]  <= simp_in;
         for (int k = 1; k < ML; k++) begin
            simp_ff[k] <= simp_ff[k-1];
         end
         early_ff[0] <= early_in;
         for (int k = 1; k < ED; k++) begin
            early_ff[k] <= early_ff[k-1];
         end
         cord_ff[0]  <= cord_res;
         for (int k = 1; k < CD; k++) begin
            cord_ff[k] <= cord_ff[k-1];
         end
         out_ff      <= out_in;
         out_op_ff   <= op_ff[PL-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_re      = out_ff.re;
   assign rsp_res_im      = out_ff.im;
   assign rsp_overflow    = out_ff.ovf;
   assign rsp_div_by_zero = out_ff.dz;

   `CNA_ASSERT_IMPL(a_dz_clean, rsp_valid && rsp_div_by_zero, out_op_ff == cna_pkg::OP_DIV && !rsp_overflow && rsp_res_re == 32'sd0 && rsp_res_im == 32'sd0, "divide by zero response not cleared")
   `CNA_ASSERT_IMPL(a_real_only, rsp_valid && (out_op_ff == cna_pkg::OP_MAG || out_op_ff == cna_pkg::OP_ANGLE), rsp_res_im == 32'sd0 && !rsp_div_by_zero, "magnitude or angle with imaginary part")
   `CNA_ASSERT_IMPL(a_angle_range, rsp_valid && out_op_ff == cna_pkg::OP_ANGLE, !rsp_overflow && rsp_res_re <= cna_pkg::PI_OUT && rsp_res_re >= -cna_pkg::PI_OUT, "angle outside plus or minus pi")

endmodule
